/* rtl/segment_intersection_defines.svh */
// Assertion macros shared by the segment intersection RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEGI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SEGI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/segi_pkg.sv */
// Package for the segment intersection block: coordinate width and payload types.
// Depends on nothing; used by segment_intersection and its testbench.
package segi_pkg;

    localparam int COORD_BITS = 16;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_start_x;
        logic signed [COORD_BITS-1:0] a_start_y;
        logic signed [COORD_BITS-1:0] a_end_x;
        logic signed [COORD_BITS-1:0] a_end_y;
        logic signed [COORD_BITS-1:0] b_start_x;
        logic signed [COORD_BITS-1:0] b_start_y;
        logic signed [COORD_BITS-1:0] b_end_x;
        logic signed [COORD_BITS-1:0] b_end_y;
    } seg_pair_t;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
    } seg_hit_t;

endpackage

/* rtl/segment_intersection.sv */
// Segment intersection pipeline: two 2D segments in, hit flag and crossing point out.
// Depends on segi_pkg and on the macros in segment_intersection_defines.svh.
//
//   Channel   Direction   Handshake           Payload
//   s_        in          s_valid / s_ready   segi_pkg::seg_pair_t (two segments)
//   m_        out         m_valid / m_ready   segi_pkg::seg_hit_t (hit, cross_x, cross_y)
//
// One request is taken in every cycle unless the output stalls; its result is registered
// in the front stages, then in the divider, which resolves one quotient bit per stage.
// Reset clears only the valid bits of the stages and the output register.
// A stalled output freezes the whole pipeline in place, so s_ready is low only while a
// result waits and m_ready is low.
`include "segment_intersection_defines.svh"

module segment_intersection (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  segi_pkg::seg_pair_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output segi_pkg::seg_hit_t   m_data
);

    localparam int CB    = segi_pkg::COORD_BITS;
    localparam int DW    = CB + 1;
    localparam int PRW   = 2 * CB + 1;
    localparam int NW    = 2 * CB + 2;
    localparam int MW    = 2 * CB + 1;
    localparam int XW    = MW + 2;
    localparam int VW    = CB + 2;
    localparam int STEPS = CB;

    typedef struct packed {
        logic signed [CB-1:0] ax0;
        logic signed [CB-1:0] ay0;
        logic signed [DW-1:0] dax;
        logic signed [DW-1:0] day;
        logic signed [DW-1:0] dbx;
        logic signed [DW-1:0] dby;
        logic signed [DW-1:0] wx;
        logic signed [DW-1:0] wy;
    } st1_t;

    typedef struct packed {
        logic signed [CB-1:0]  ax0;
        logic signed [CB-1:0]  ay0;
        logic signed [DW-1:0]  dax;
        logic signed [DW-1:0]  day;
        logic signed [PRW-1:0] den_a;
        logic signed [PRW-1:0] den_b;
        logic signed [PRW-1:0] sn_a;
        logic signed [PRW-1:0] sn_b;
        logic signed [PRW-1:0] tn_a;
        logic signed [PRW-1:0] tn_b;
    } st2_t;

    typedef struct packed {
        logic signed [CB-1:0] ax0;
        logic signed [CB-1:0] ay0;
        logic signed [DW-1:0] dax;
        logic signed [DW-1:0] day;
        logic signed [NW-1:0] den;
        logic signed [NW-1:0] sn;
        logic signed [NW-1:0] tn;
    } st3_t;

    typedef struct packed {
        logic                 hit;
        logic                 negx;
        logic                 negy;
        logic signed [CB-1:0] ax0;
        logic signed [CB-1:0] ay0;
        logic [CB-1:0]        smx;
        logic [CB-1:0]        smy;
        logic [MW-1:0]        dm;
        logic [MW-1:0]        tm;
        logic [MW-1:0]        rx;
        logic [MW-1:0]        ry;
        logic [CB-1:0]        qx;
        logic [CB-1:0]        qy;
    } div_t;

    typedef struct packed {
        logic [MW-1:0] r;
        logic [CB-1:0] q;
    } step_t;

    function automatic logic signed [DW-1:0] ext(input logic signed [CB-1:0] v);
        return DW'(v);
    endfunction

    function automatic step_t div_step(input logic [MW-1:0] r, input logic [CB-1:0] q,
                                       input logic b, input logic [MW-1:0] tm,
                                       input logic [MW-1:0] dm);
        logic [XW-1:0] x;
        logic [XW-1:0] d1;
        logic [XW-1:0] d2;
        step_t         o;
        x  = XW'({r, 1'b0}) + (b ? XW'(tm) : '0);
        d1 = XW'(dm);
        d2 = XW'({dm, 1'b0});
        if (x >= d2) begin
            o.r = MW'(x - d2);
            o.q = CB'({q, 1'b0}) + CB'(2);
        end else if (x >= d1) begin
            o.r = MW'(x - d1);
            o.q = {q[CB-2:0], 1'b1};
        end else begin
            o.r = MW'(x);
            o.q = {q[CB-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic div_t div_adv(input div_t d, input logic bx, input logic by);
        div_t  o;
        step_t sx;
        step_t sy;
        o    = d;
        sx   = div_step(d.rx, d.qx, bx, d.tm, d.dm);
        sy   = div_step(d.ry, d.qy, by, d.tm, d.dm);
        o.rx = sx.r;
        o.qx = sx.q;
        o.ry = sy.r;
        o.qy = sy.q;
        return o;
    endfunction

    function automatic logic [CB-1:0] place_fin(input logic signed [CB-1:0] base,
                                                input logic [CB-1:0] q, input logic rnz,
                                                input logic neg);
        logic signed [VW-1:0] sb;
        logic signed [VW-1:0] sq;
        logic signed [VW-1:0] v;
        sb = VW'(base);
        sq = signed'(VW'(q));
        if (neg) begin
            v = sb - sq;
            if (rnz && !v[VW-1] && (v != '0)) begin
                v = v - VW'(1);
            end
        end else begin
            v = sb + sq;
            if (rnz && v[VW-1]) begin
                v = v + VW'(1);
            end
        end
        return v[CB-1:0];
    endfunction

    logic               adv;
    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic [STEPS:0]     dvld_reg;
    logic               out_vld_reg;
    st1_t               st1_reg;
    st1_t               st1_next;
    st2_t               st2_reg;
    st2_t               st2_next;
    st3_t               st3_reg;
    st3_t               st3_next;
    div_t               div_in;
    div_t               div_reg  [0:STEPS];
    div_t               div_next [0:STEPS];
    segi_pkg::seg_hit_t out_reg;
    segi_pkg::seg_hit_t out_next;

    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    always_comb begin
        st1_next.ax0 = s_data.a_start_x;
        st1_next.ay0 = s_data.a_start_y;
        st1_next.dax = ext(s_data.a_end_x) - ext(s_data.a_start_x);
        st1_next.day = ext(s_data.a_end_y) - ext(s_data.a_start_y);
        st1_next.dbx = ext(s_data.b_end_x) - ext(s_data.b_start_x);
        st1_next.dby = ext(s_data.b_end_y) - ext(s_data.b_start_y);
        st1_next.wx  = ext(s_data.a_start_x) - ext(s_data.b_start_x);
        st1_next.wy  = ext(s_data.a_start_y) - ext(s_data.b_start_y);
    end

    always_comb begin
        st2_next.ax0   = st1_reg.ax0;
        st2_next.ay0   = st1_reg.ay0;
        st2_next.dax   = st1_reg.dax;
        st2_next.day   = st1_reg.day;
        st2_next.den_a = PRW'(st1_reg.dax) * PRW'(st1_reg.dby);
        st2_next.den_b = PRW'(st1_reg.dbx) * PRW'(st1_reg.day);
        st2_next.sn_a  = PRW'(st1_reg.dax) * PRW'(st1_reg.wy);
        st2_next.sn_b  = PRW'(st1_reg.day) * PRW'(st1_reg.wx);
        st2_next.tn_a  = PRW'(st1_reg.dbx) * PRW'(st1_reg.wy);
        st2_next.tn_b  = PRW'(st1_reg.dby) * PRW'(st1_reg.wx);
    end

    always_comb begin
        st3_next.ax0 = st2_reg.ax0;
        st3_next.ay0 = st2_reg.ay0;
        st3_next.dax = st2_reg.dax;
        st3_next.day = st2_reg.day;
        st3_next.den = NW'(st2_reg.den_a) - NW'(st2_reg.den_b);
        st3_next.sn  = NW'(st2_reg.sn_a) - NW'(st2_reg.sn_b);
        st3_next.tn  = NW'(st2_reg.tn_a) - NW'(st2_reg.tn_b);
    end

    // A negative denominator excludes both endpoints of the parameter range.
    always_comb begin
        logic den_neg;
        logic den_zero;
        logic sn_neg;
        logic tn_neg;
        logic sn_gt;
        logic tn_gt;
        den_neg  = st3_reg.den[NW-1];
        den_zero = (st3_reg.den == '0);
        sn_neg   = st3_reg.sn[NW-1];
        tn_neg   = st3_reg.tn[NW-1];
        sn_gt    = (st3_reg.sn > st3_reg.den);
        tn_gt    = (st3_reg.tn > st3_reg.den);
        div_in.hit  = !den_zero && (den_neg ? (sn_neg && tn_neg && sn_gt && tn_gt)
                                            : (!sn_neg && !tn_neg && !sn_gt && !tn_gt));
        div_in.negx = st3_reg.dax[DW-1] ^ tn_neg ^ den_neg;
        div_in.negy = st3_reg.day[DW-1] ^ tn_neg ^ den_neg;
        div_in.ax0  = st3_reg.ax0;
        div_in.ay0  = st3_reg.ay0;
        div_in.smx  = CB'(st3_reg.dax[DW-1] ? -st3_reg.dax : st3_reg.dax);
        div_in.smy  = CB'(st3_reg.day[DW-1] ? -st3_reg.day : st3_reg.day);
        div_in.dm   = MW'(den_neg ? -st3_reg.den : st3_reg.den);
        div_in.tm   = MW'(tn_neg ? -st3_reg.tn : st3_reg.tn);
        div_in.rx   = '0;
        div_in.ry   = '0;
        div_in.qx   = '0;
        div_in.qy   = '0;
    end

    assign div_next[0] = div_in;

    for (genvar s = 0; s < STEPS; s++) begin : g_div
        localparam int BIT = STEPS - 1 - s;
        assign div_next[s+1] = div_adv(div_reg[s], div_reg[s].smx[BIT], div_reg[s].smy[BIT]);
    end

    always_comb begin
        out_next.hit     = div_reg[STEPS].hit;
        out_next.cross_x = '0;
        out_next.cross_y = '0;
        if (div_reg[STEPS].hit) begin
            out_next.cross_x = place_fin(div_reg[STEPS].ax0, div_reg[STEPS].qx,
                                         div_reg[STEPS].rx != '0, div_reg[STEPS].negx);
            out_next.cross_y = place_fin(div_reg[STEPS].ay0, div_reg[STEPS].qy,
                                         div_reg[STEPS].ry != '0, div_reg[STEPS].negy);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            dvld_reg    <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            dvld_reg    <= {dvld_reg[STEPS-1:0], v3_reg};
            out_vld_reg <= dvld_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            for (int i = 0; i <= STEPS; i++) begin
                div_reg[i] <= div_next[i];
            end
            out_reg <= out_next;
        end
    end

    `SEGI_ASSERT_NOW(a_hit_operands, aclk, aresetn, dvld_reg[0] && div_reg[0].hit,
        (div_reg[0].dm != '0) && (div_reg[0].tm <= div_reg[0].dm),
        "hit request entered the divider with a zero or too small denominator")
    `SEGI_ASSERT_NOW(a_quot_bound, aclk, aresetn, dvld_reg[STEPS] && div_reg[STEPS].hit,
        (div_reg[STEPS].qx <= div_reg[STEPS].smx) && (div_reg[STEPS].qy <= div_reg[STEPS].smy),
        "quotient exceeds the direction magnitude on a hit")
    `SEGI_ASSERT_NOW(a_miss_zero, aclk, aresetn, out_vld_reg && !out_reg.hit,
        (out_reg.cross_x == '0) && (out_reg.cross_y == '0),
        "miss result carries a non-zero crossing point")
    `SEGI_ASSERT_NEXT(a_stall_hold, aclk, aresetn, !adv,
        $stable(dvld_reg) && $stable(v3_reg) && $stable(v1_reg),
        "pipeline valid bits moved while the output was stalled")

endmodule

/* test/tb_segment_intersection.sv */
// Self-checking testbench for segment_intersection: a directed table, then random segment
// pairs, with bursty requests and a stalling receiver. Depends on segi_pkg and the RTL.
module tb_segment_intersection;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PAIRS    = 850;
    localparam int DRAIN_CYCLES    = 2 * (segi_pkg::COORD_BITS + 4);
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DIRECTED_ROWS   = 20;

    // Columns: a_start x/y, a_end x/y, b_start x/y, b_end x/y, result known, hit, x, y.
    localparam int DIRECTED [DIRECTED_ROWS][12] = '{
        '{     0,      0,      0,      0,      0,      0,      0,      0, 1, 0, 0, 0},
        '{     0,      0,     10,     10,      0,     10,     10,      0, 1, 1, 5, 5},
        '{     0,      0,    100,      0,      0,      5,    100,      5, 1, 0, 0, 0},
        '{     0,      0,     10,      0,      5,      0,     15,      0, 1, 0, 0, 0},
        '{     5,      0,      5,      0,      0,      0,     10,      0, 1, 0, 0, 0},
        '{ 32767,  32767,  32767,  32767,  32767,  32767,  32767,  32767, 1, 0, 0, 0},
        '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1, 0, 0, 0},
        '{     0,      0,      1,      0,      5,     -1,      5,      1, 0, 0, 0, 0},
        '{     0,      0,     10,      0,      5,      1,      5,     20, 0, 0, 0, 0},
        '{     0,      0,     10,      0,      0,      0,      0,     10, 0, 0, 0, 0},
        '{     0,      0,     10,      0,      0,      0,      0,    -10, 0, 0, 0, 0},
        '{     0,      0,     10,      0,     10,      0,     10,     10, 0, 0, 0, 0},
        '{     0,      0,     10,      0,     10,      0,     10,    -10, 0, 0, 0, 0},
        '{     0,      0,     10,      0,      5,     -5,      5,      5, 0, 0, 0, 0},
        '{     0,      0,     10,      0,      5,      5,      5,     -5, 0, 0, 0, 0},
        '{     0,      0,      3,      1,      1,      0,      1,      1, 0, 0, 0, 0},
        '{     0,      0,     -3,     -1,     -1,      0,     -1,     -1, 0, 0, 0, 0},
        '{-32768, -32768,  32767,  32767, -32768,  32767,  32767, -32768, 0, 0, 0, 0},
        '{-32768,      0,  32767,      0,      0, -32768,      0,  32767, 0, 0, 0, 0},
        '{ 32767, -32768, -32768,  32767, -32768, -32768,  32767,  32767, 0, 0, 0, 0}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    segi_pkg::seg_pair_t s_data;
    logic                m_valid;
    logic                m_ready;
    segi_pkg::seg_hit_t  m_data;

    logic                chk_known;
    segi_pkg::seg_hit_t  chk_want;
    segi_pkg::seg_hit_t  pending_crossings [$];
    segi_pkg::seg_hit_t  oldest;
    int                  pairs_taken;
    int                  fault_count;
    int                  cycle_count;

    segment_intersection dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic segi_pkg::seg_hit_t crossing_of(input segi_pkg::seg_pair_t p);
        longint ax0, ay0, dax, day, dbx, dby, wx, wy, den, sn, tn;
        bit     on_both;
        segi_pkg::seg_hit_t r;
        ax0 = longint'(p.a_start_x);
        ay0 = longint'(p.a_start_y);
        dax = longint'(p.a_end_x) - ax0;
        day = longint'(p.a_end_y) - ay0;
        dbx = longint'(p.b_end_x) - longint'(p.b_start_x);
        dby = longint'(p.b_end_y) - longint'(p.b_start_y);
        wx  = ax0 - longint'(p.b_start_x);
        wy  = ay0 - longint'(p.b_start_y);
        den = dax * dby - dbx * day;
        sn  = dax * wy - day * wx;
        tn  = dbx * wy - dby * wx;
        r   = '0;
        // A negative denominator excludes both endpoints, a positive one includes them.
        if (den > 0) begin
            on_both = sn >= 0 && tn >= 0 && sn <= den && tn <= den;
        end else if (den < 0) begin
            on_both = sn < 0 && tn < 0 && sn > den && tn > den;
        end else begin
            on_both = 1'b0;
        end
        if (on_both) begin
            r.hit     = 1'b1;
            r.cross_x = 16'((ax0 * den + dax * tn) / den);
            r.cross_y = 16'((ay0 * den + day * tn) / den);
        end
        return r;
    endfunction

    function automatic int spread(input int reach);
        return int'($urandom_range(0, 2 * reach)) - reach;
    endfunction

    function automatic segi_pkg::seg_pair_t random_pair();
        int                  kind, scale, cx, cy, ux, uy, vx, vy, ox, oy;
        int                  corners [7];
        segi_pkg::seg_pair_t p;
        corners = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            p = {$urandom(), $urandom(), $urandom(), $urandom()};
        end else if (kind < 48) begin
            // Two segments built through a common point, with an occasional nudge off it.
            case ($urandom_range(0, 2))
                0:       scale = 4;
                1:       scale = 64;
                default: scale = 2000;
            endcase
            cx = spread(8000);
            cy = spread(8000);
            ux = spread(scale);
            uy = spread(scale);
            vx = spread(scale);
            vy = spread(scale);
            p.a_start_x = 16'(cx - ux * int'($urandom_range(0, 3)));
            p.a_start_y = 16'(cy - uy * int'($urandom_range(0, 3)));
            p.a_end_x   = 16'(cx + ux * int'($urandom_range(0, 3)));
            p.a_end_y   = 16'(cy + uy * int'($urandom_range(0, 3)));
            p.b_start_x = 16'(cx - vx * int'($urandom_range(0, 3)) + spread(1));
            p.b_start_y = 16'(cy - vy * int'($urandom_range(0, 3)));
            p.b_end_x   = 16'(cx + vx * int'($urandom_range(0, 3)));
            p.b_end_y   = 16'(cy + vy * int'($urandom_range(0, 3)) + spread(1));
        end else if (kind < 62) begin
            for (int c = 0; c < 8; c++) begin
                p[16*c +: 16] = 16'(spread(12));
            end
        end else if (kind < 76) begin
            p.a_start_x = 16'(spread(20000));
            p.a_start_y = 16'(spread(20000));
            p.a_end_x   = 16'(spread(20000));
            p.a_end_y   = 16'(spread(20000));
            ox = spread(20000);
            oy = spread(20000);
            if ($urandom_range(0, 1) == 0) begin
                p.b_start_x = p.a_start_x;
                p.b_start_y = p.a_start_y;
            end else begin
                p.b_start_x = p.a_end_x;
                p.b_start_y = p.a_end_y;
            end
            p.b_end_x = 16'(ox);
            p.b_end_y = 16'(oy);
            if ($urandom_range(0, 1) == 0) begin
                p = {p.a_start_x, p.a_start_y, p.a_end_x, p.a_end_y,
                     p.b_end_x, p.b_end_y, p.b_start_x, p.b_start_y};
            end
        end else if (kind < 86) begin
            p.a_start_x = 16'(spread(16000));
            p.a_start_y = 16'(spread(16000));
            p.a_end_x   = 16'(spread(16000));
            p.a_end_y   = 16'(spread(16000));
            ox = spread(40);
            oy = spread(40);
            p.b_start_x = 16'(int'(p.a_start_x) + ox);
            p.b_start_y = 16'(int'(p.a_start_y) + oy);
            p.b_end_x   = 16'(int'(p.a_end_x) + ox);
            p.b_end_y   = 16'(int'(p.a_end_y) + oy);
        end else begin
            for (int c = 0; c < 8; c++) begin
                p[16*c +: 16] = 16'(corners[$urandom_range(0, 6)]);
            end
        end
        return p;
    endfunction

    task automatic present_pair(input segi_pkg::seg_pair_t pair, input logic known,
                                input segi_pkg::seg_hit_t want);
        s_valid   <= 1'b1;
        s_data    <= pair;
        chk_known <= known;
        chk_want  <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic log_fault(input string what);
        fault_count++;
        if (fault_count <= 10) $display("%0t: %s", $time, what);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_crossings.size() == 0) begin
                    log_fault($sformatf("unexpected result hit=%0b x=%0d y=%0d",
                                        m_data.hit, m_data.cross_x, m_data.cross_y));
                end else begin
                    oldest = pending_crossings.pop_front();
                    if (m_data.hit !== oldest.hit || m_data.cross_x !== oldest.cross_x
                            || m_data.cross_y !== oldest.cross_y) begin
                        log_fault($sformatf(
                            "mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                            oldest.hit, oldest.cross_x, oldest.cross_y,
                            m_data.hit, m_data.cross_x, m_data.cross_y));
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_crossings.push_back(chk_known ? chk_want : crossing_of(s_data));
                pairs_taken++;
            end
        end
    end

    initial begin : receiver
        int  mode;
        int  stretch;
        bit  held_off;
        held_off = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(8, 60);
            repeat (stretch) begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ~m_ready;
                endcase
                @(posedge aclk);
            end
            if (!held_off && pairs_taken >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("segment_intersection test failed");
        $finish;
    end

    initial begin : stimulus
        segi_pkg::seg_pair_t pair;
        int                  idx;
        int                  burst;
        pairs_taken = 0;
        fault_count = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        chk_known <= 1'b0;
        chk_want  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idx = 0;
        while (idx < DIRECTED_ROWS + RANDOM_PAIRS) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && idx < DIRECTED_ROWS + RANDOM_PAIRS) begin
                if (idx < DIRECTED_ROWS) begin
                    for (int c = 0; c < 8; c++) begin
                        pair[16*(7-c) +: 16] = DIRECTED[idx][c][15:0];
                    end
                    present_pair(pair, DIRECTED[idx][8] != 0,
                                 {1'(DIRECTED[idx][9]), 16'(DIRECTED[idx][10]),
                                  16'(DIRECTED[idx][11])});
                end else begin
                    present_pair(random_pair(), 1'b0, '0);
                end
                idx++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        while (pending_crossings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("segment_intersection test passed");
        end else begin
            $display("segment_intersection test failed");
        end
        $finish;
    end

endmodule
